>>> rtl/isoline_triangle_segments_core_assert.svh
// assertion macros for the isoline segment core
`ifndef ISOLINE_TRIANGLE_SEGMENTS_CORE_ASSERT_SVH
`define ISOLINE_TRIANGLE_SEGMENTS_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ITS_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ITS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/its_pkg.sv
// shared types, codes and helpers of the isoline segment core
package its_pkg;

    localparam int GRID_W_BITS = 11;
    localparam logic [GRID_W_BITS-1:0] GRID_W_RESET = 11'd1024;

    // configuration register indexes
    localparam logic CFG_IDX_LEVEL = 1'b0;
    localparam logic CFG_IDX_WIDTH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_WAIT,
        S_EMIT
    } state_t;

    // triangle edges by corner pair: p0 = (x,y), p1 = (x+1,y+1), p2 = third corner
    typedef enum logic [1:0] {
        EDGE_01,
        EDGE_02,
        EDGE_12
    } edge_t;

    typedef struct packed {
        logic  hit;
        edge_t first;
        edge_t second;
    } tri_sel_t;

    typedef struct packed {
        logic ax;
        logic ay;
        logic bx;
        logic by;
    } ends_t;

    // pick the first two crossed edges in the fixed edge order
    function automatic tri_sel_t tri_pick(input logic e01, input logic e02, input logic e12);
        tri_sel_t r;
        r.hit    = (e01 && (e02 || e12)) || (e02 && e12);
        r.first  = e01 ? EDGE_01 : EDGE_02;
        r.second = (e01 && e02) ? EDGE_02 : EDGE_12;
        return r;
    endfunction

    // local corner offsets of an edge; third corner is (1,0) or (0,1)
    function automatic ends_t edge_ends(input logic tri_sel, input edge_t code);
        ends_t r;
        unique case (code)
            EDGE_01: r = '{ax: 1'b0, ay: 1'b0, bx: 1'b1, by: 1'b1};
            EDGE_02: r = '{ax: 1'b0, ay: 1'b0, bx: !tri_sel, by: tri_sel};
            EDGE_12: r = '{ax: 1'b1, ay: 1'b1, bx: !tri_sel, by: tri_sel};
            default: r = '{ax: 1'b0, ay: 1'b0, bx: 1'b0, by: 1'b0};
        endcase
        return r;
    endfunction

endpackage

>>> rtl/its_if.sv
// stream and configuration interfaces of the isoline segment core
interface its_in_if #(parameter int SW = 16) ();
    logic                 valid;
    logic                 ready;
    logic signed [SW-1:0] sample;
    logic                 start_of_frame;

    modport source (output valid, sample, start_of_frame, input ready);
    modport sink (input valid, sample, start_of_frame, output ready);
endinterface

interface its_out_if #(
    parameter int CXW = 10,
    parameter int CYW = 10,
    parameter int PXW = 26,
    parameter int PYW = 26
) ();
    logic           valid;
    logic           ready;
    logic [CXW-1:0] cell_x;
    logic [CYW-1:0] cell_y;
    logic           triangle;
    logic [PXW-1:0] start_x;
    logic [PYW-1:0] start_y;
    logic [PXW-1:0] end_x;
    logic [PYW-1:0] end_y;
    logic           last_of_cell;

    modport source (output valid, cell_x, cell_y, triangle, start_x, start_y, end_x, end_y,
                    last_of_cell, input ready);
    modport sink (input valid, cell_x, cell_y, triangle, start_x, start_y, end_x, end_y,
                  last_of_cell, output ready);
endinterface

interface its_cfg_if #(parameter int DW = 16) ();
    logic          valid;
    logic          ready;
    logic          index;
    logic [DW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/its_ram.sv
// generic single-port-write ram with registered read
module its_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/its_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module its_div #(
    parameter int NW = 17,
    parameter int DW = 18,
    parameter int QW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [QW-1:0] quo
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [QW-1:0]   quo_reg, quo_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DW:0]     shifted;
    logic            fits;

    assign shifted = {rem_reg, 1'b0};
    assign fits    = shifted >= {1'b0, den_reg};

    // one shift-and-subtract step per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = DW'(num);
            den_next  = den;
            quo_next  = '0;
            cnt_next  = CNTW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? DW'(shifted - {1'b0, den_reg}) : DW'(shifted);
            quo_next = {quo_reg[QW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/isoline_triangle_segments_core.sv
// isoline segment core: marching triangles over a raster grid, one sample at a time
// a dropped sample leaves the core idle; one with no segment returns to idle after the
// eval state; each crossing takes a pass through the shared serial divider (div, wait),
// and each segment an emit state that waits for a free output slot
// one sample is taken at a time, paced by the divider loop; the output register holds
// a segment while the next sample is taken. reset clears control state; the line store
// is not cleared and needs no clearing pass
module isoline_triangle_segments_core
    import its_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    its_in_if.sink    samples,
    its_out_if.source segments,
    its_cfg_if.sink   cfg
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int SW  = SAMPLE_BITS;
    localparam int DFW = SW + 1;
    localparam int MW  = SW + 1;
    localparam int DNW = SW + 2;
    localparam int PXW = AW + FRAC_BITS;
    localparam int PYW = RW + FRAC_BITS;

    state_t state_reg, state_next;

    logic signed [SW-1:0]  level_reg, level_next;
    logic [GRID_W_BITS-1:0] gw_reg, gw_next;

    logic [AW-1:0] column_count_reg, column_count_next;
    logic [RW-1:0] row_count_reg, row_count_next;
    logic          frame_full_reg, frame_full_next;

    logic signed [SW-1:0] left_reg, left_next;
    logic signed [SW-1:0] upper_left_reg, upper_left_next;
    logic signed [SW-1:0] cur_reg, cur_next;
    logic [AW-1:0]        col_reg, col_next;
    logic [AW-1:0]        x_reg, x_next;
    logic [RW-1:0]        y_reg, y_next;
    logic                 cell_reg, cell_next;

    logic signed [DFW-1:0] v00_reg, v00_next;
    logic signed [DFW-1:0] v11_reg, v11_next;
    logic signed [DFW-1:0] v01_reg, v01_next;
    logic signed [DFW-1:0] v10_reg, v10_next;
    tri_sel_t              sel0_reg, sel0_next;
    tri_sel_t              sel1_reg, sel1_next;
    logic                  tri_reg, tri_next;
    logic                  k_reg, k_next;
    logic [PXW-1:0]        px0_reg, px0_next;
    logic [PYW-1:0]        py0_reg, py0_next;
    logic [PXW-1:0]        px1_reg, px1_next;
    logic [PYW-1:0]        py1_reg, py1_next;

    logic           out_valid_reg, out_valid_next;
    logic [AW-1:0]  o_cx_reg, o_cx_next;
    logic [RW-1:0]  o_cy_reg, o_cy_next;
    logic           o_tri_reg, o_tri_next;
    logic [PXW-1:0] o_sx_reg, o_sx_next;
    logic [PYW-1:0] o_sy_reg, o_sy_next;
    logic [PXW-1:0] o_ex_reg, o_ex_next;
    logic [PYW-1:0] o_ey_reg, o_ey_next;
    logic           o_last_reg, o_last_next;

    logic [31:0]   w_eff;
    logic [AW-1:0] col_sel;
    logic [RW-1:0] row_eff;
    logic          full_eff;
    logic          in_xfer;
    logic          out_load;
    logic          slot_free;

    logic                  ram_we;
    logic                  ram_re;
    logic [SW-1:0]         ram_rdata;
    logic signed [SW-1:0]  up;
    logic signed [DFW-1:0] lv;
    logic signed [DFW-1:0] d00, d01, d10, d11;
    tri_sel_t              pick0, pick1;

    edge_t                 cur_edge;
    ends_t                 ends;
    logic signed [DFW-1:0] va, vb, v2;
    logic [MW-1:0]         mag_a, mag_b;
    logic [DNW-1:0]        den;
    logic                  div_start;
    logic                  div_done;
    logic [FRAC_BITS-1:0]  frac;
    logic [PXW-1:0]        pt_x;
    logic [PYW-1:0]        pt_y;

    function automatic logic opp(input logic signed [DFW-1:0] a, input logic signed [DFW-1:0] b);
        return (a < 0 && b > 0) || (a > 0 && b < 0);
    endfunction

    // configuration writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        level_next = level_reg;
        gw_next    = gw_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_IDX_LEVEL: level_next = cfg.data[SW-1:0];
                CFG_IDX_WIDTH: gw_next    = cfg.data[GRID_W_BITS-1:0];
                default:       level_next = level_reg;
            endcase
        end
    end

    // effective width and current position
    always_comb
    begin
        if (32'(gw_reg) < 32'd2)
        begin
            w_eff = 32'd2;
        end
        else if (32'(gw_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = 32'(MAX_WIDTH);
        end
        else
        begin
            w_eff = 32'(gw_reg);
        end
        full_eff = samples.start_of_frame ? 1'b0 : frame_full_reg;
        row_eff  = samples.start_of_frame ? '0 : row_count_reg;
        col_sel  = samples.start_of_frame ? '0 : column_count_reg;
        if (32'(col_sel) >= w_eff)
        begin
            col_sel = AW'(w_eff - 32'd1);
        end
    end

    assign samples.ready = (state_reg == S_IDLE);
    assign in_xfer       = samples.valid && samples.ready;

    // line store
    assign ram_re = in_xfer;
    assign ram_we = (state_reg == S_EVAL);

    its_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (col_reg),
        .wdata (cur_reg),
        .re    (ram_re),
        .raddr (col_sel),
        .rdata (ram_rdata)
    );

    // corner values relative to the level and crossed edges
    assign up  = ram_rdata;
    assign lv  = {level_reg[SW-1], level_reg};
    assign d00 = $signed({upper_left_reg[SW-1], upper_left_reg}) - lv;
    assign d01 = $signed({up[SW-1], up}) - lv;
    assign d10 = $signed({left_reg[SW-1], left_reg}) - lv;
    assign d11 = $signed({cur_reg[SW-1], cur_reg}) - lv;
    assign pick0 = tri_pick(opp(d00, d11), opp(d00, d01), opp(d11, d01));
    assign pick1 = tri_pick(opp(d00, d11), opp(d00, d10), opp(d11, d10));

    // edge under division and its end values
    always_comb
    begin
        cur_edge = k_reg ? (tri_reg ? sel1_reg.second : sel0_reg.second)
                         : (tri_reg ? sel1_reg.first : sel0_reg.first);
        v2 = tri_reg ? v10_reg : v01_reg;
        case (cur_edge)
            EDGE_01:
            begin
                va = v00_reg;
                vb = v11_reg;
            end
            EDGE_02:
            begin
                va = v00_reg;
                vb = v2;
            end
            default:
            begin
                va = v11_reg;
                vb = v2;
            end
        endcase
        mag_a = va[DFW-1] ? MW'($unsigned(-va)) : MW'($unsigned(va));
        mag_b = vb[DFW-1] ? MW'($unsigned(-vb)) : MW'($unsigned(vb));
        den   = DNW'(mag_a) + DNW'(mag_b);
        ends  = edge_ends(tri_reg, cur_edge);
    end

    assign div_start = (state_reg == S_DIV);

    its_div #(
        .NW (MW),
        .DW (DNW),
        .QW (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mag_a),
        .den   (den),
        .done  (div_done),
        .quo   (frac)
    );

    // crossing point from the fraction
    always_comb
    begin
        pt_x = {x_reg + AW'(ends.ax), {FRAC_BITS{1'b0}}};
        pt_y = {y_reg + RW'(ends.ay), {FRAC_BITS{1'b0}}};
        if (ends.bx && !ends.ax)
        begin
            pt_x = pt_x + PXW'(frac);
        end
        else if (!ends.bx && ends.ax)
        begin
            pt_x = pt_x - PXW'(frac);
        end
        if (ends.by && !ends.ay)
        begin
            pt_y = pt_y + PYW'(frac);
        end
        else if (!ends.by && ends.ay)
        begin
            pt_y = pt_y - PYW'(frac);
        end
    end

    assign slot_free = !out_valid_reg || segments.ready;
    assign out_load  = (state_reg == S_EMIT) && slot_free;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        frame_full_next   = frame_full_reg;
        left_next         = left_reg;
        upper_left_next   = upper_left_reg;
        cur_next          = cur_reg;
        col_next          = col_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        cell_next         = cell_reg;
        v00_next          = v00_reg;
        v11_next          = v11_reg;
        v01_next          = v01_reg;
        v10_next          = v10_reg;
        sel0_next         = sel0_reg;
        sel1_next         = sel1_reg;
        tri_next          = tri_reg;
        k_next            = k_reg;
        px0_next          = px0_reg;
        py0_next          = py0_reg;
        px1_next          = px1_reg;
        py1_next          = py1_reg;
        out_valid_next    = out_valid_reg && !segments.ready;
        o_cx_next         = o_cx_reg;
        o_cy_next         = o_cy_reg;
        o_tri_next        = o_tri_reg;
        o_sx_next         = o_sx_reg;
        o_sy_next         = o_sy_reg;
        o_ex_next         = o_ex_reg;
        o_ey_next         = o_ey_reg;
        o_last_next       = o_last_reg;
        if (state_reg == S_EVAL)
        begin
            v00_next = d00;
            v01_next = d01;
            v10_next = d10;
            v11_next = d11;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    frame_full_next   = full_eff;
                    column_count_next = col_sel;
                    row_count_next    = row_eff;
                    if (!full_eff)
                    begin
                        cur_next  = samples.sample;
                        col_next  = col_sel;
                        x_next    = col_sel - 1'b1;
                        y_next    = row_eff - 1'b1;
                        cell_next = (col_sel != '0) && (row_eff != '0);
                        if (32'(col_sel) + 32'd1 >= w_eff)
                        begin
                            column_count_next = '0;
                            row_count_next    = row_eff + 1'b1;
                            frame_full_next   = (32'(row_eff) + 32'd1 >= 32'(MAX_HEIGHT));
                        end
                        else
                        begin
                            column_count_next = col_sel + 1'b1;
                        end
                        state_next = S_EVAL;
                    end
                end
            end
            S_EVAL:
            begin
                upper_left_next = up;
                left_next       = cur_reg;
                sel0_next       = pick0;
                sel1_next       = pick1;
                tri_next        = !pick0.hit;
                k_next          = 1'b0;
                if (cell_reg && (pick0.hit || pick1.hit))
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (div_done)
                begin
                    if (k_reg)
                    begin
                        px1_next   = pt_x;
                        py1_next   = pt_y;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        px0_next   = pt_x;
                        py0_next   = pt_y;
                        k_next     = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    o_cx_next      = x_reg;
                    o_cy_next      = y_reg;
                    o_tri_next     = tri_reg;
                    o_sx_next      = px0_reg;
                    o_sy_next      = py0_reg;
                    o_ex_next      = px1_reg;
                    o_ey_next      = py1_reg;
                    o_last_next    = tri_reg || !sel1_reg.hit;
                    if (!tri_reg && sel1_reg.hit)
                    begin
                        tri_next   = 1'b1;
                        k_next     = 1'b0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            level_reg        <= '0;
            gw_reg           <= GRID_W_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            frame_full_reg   <= 1'b0;
            left_reg         <= '0;
            upper_left_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            level_reg        <= level_next;
            gw_reg           <= gw_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            frame_full_reg   <= frame_full_next;
            left_reg         <= left_next;
            upper_left_reg   <= upper_left_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        col_reg    <= col_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        cell_reg   <= cell_next;
        v00_reg    <= v00_next;
        v11_reg    <= v11_next;
        v01_reg    <= v01_next;
        v10_reg    <= v10_next;
        sel0_reg   <= sel0_next;
        sel1_reg   <= sel1_next;
        tri_reg    <= tri_next;
        k_reg      <= k_next;
        px0_reg    <= px0_next;
        py0_reg    <= py0_next;
        px1_reg    <= px1_next;
        py1_reg    <= py1_next;
        o_cx_reg   <= o_cx_next;
        o_cy_reg   <= o_cy_next;
        o_tri_reg  <= o_tri_next;
        o_sx_reg   <= o_sx_next;
        o_sy_reg   <= o_sy_next;
        o_ex_reg   <= o_ex_next;
        o_ey_reg   <= o_ey_next;
        o_last_reg <= o_last_next;
    end

    // output channel
    assign segments.valid        = out_valid_reg;
    assign segments.cell_x       = o_cx_reg;
    assign segments.cell_y       = o_cy_reg;
    assign segments.triangle     = o_tri_reg;
    assign segments.start_x      = o_sx_reg;
    assign segments.start_y      = o_sy_reg;
    assign segments.end_x        = o_ex_reg;
    assign segments.end_y        = o_ey_reg;
    assign segments.last_of_cell = o_last_reg;

    // checks
`include "isoline_triangle_segments_core_assert.svh"

    `ITS_ASSERT_NOW(a_done_in_wait, div_done, state_reg == S_WAIT, "divider done outside wait")
    `ITS_ASSERT_NOW(a_load_free, out_load, !out_valid_reg || segments.ready, "output overwrite")
    `ITS_ASSERT_NEXT(a_kept_eval, in_xfer && !full_eff, state_reg == S_EVAL, "missed eval")

endmodule
